FILE: hw/rtl/clock_page_replacement_assert.svh
// assertion macros for the clock page replacement block
`ifndef CLOCK_PAGE_REPLACEMENT_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_ASSERT_SVH

// condition holds in the same cycle
`define CPR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define CPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cpr_pkg.sv
package cpr_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef enum logic {
        CMD_ACCESS = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    localparam int FRAME_W   = 4;
    localparam int REMOVED_W = 5;
    localparam int FAULT_W   = 32;
    localparam int M_DATA_W  = 48;

endpackage

FILE: hw/rtl/cpr_frame_ram.sv
module cpr_frame_ram #(
    parameter int DEPTH = 16,
    parameter int DW    = 37,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    // an entry never written reads as an empty frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

FILE: hw/rtl/clock_page_replacement.sv
// a hit ends the scan at the matching frame, a remove scans all frames, and a miss scans all
// frames and then sweeps for a frame to fill (one frame memory read per cycle)
// throughput: one item at a time; the next input is taken the cycle after the result is
// loaded into the output register, whose transfer may still be pending
// reset: synchronous active-low aresetn empties all frames at once through per-frame
// valid bits and clears hand, fault count and counting flag; no clearing pass
module clock_page_replacement #(
    parameter int NUM_FRAMES = 16,
    parameter int ID_BITS    = 16,
    parameter int PAGE_BITS  = 20
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // proc_id, page_num
    input  logic [((ID_BITS+PAGE_BITS+7)/8)*8-1:0] s_tdata,
    // cmd
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // hit, frame, removed, fault_total, counting_on
    output logic [cpr_pkg::M_DATA_W-1:0] m_tdata
);

    import cpr_pkg::*;

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int ENT_W = ID_BITS + PAGE_BITS + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);
    localparam logic [CNT_W-1:0] FRAMES_CNT = CNT_W'(NUM_FRAMES);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic                 dv_reg, dv_next;
    logic [IDX_W-1:0]     dix_reg, dix_next;
    logic                 free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     frame_reg, frame_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;
    logic [IDX_W-1:0]     hand_reg, hand_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;
    logic                 cnt_en_reg, cnt_en_next;
    logic [CNT_W-1:0]     empty_reg, empty_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // frame memory port
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ENT_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
    logic [ENT_W-1:0] rdata;

    // entry just read
    logic [ID_BITS-1:0]   e_owner;
    logic [PAGE_BITS-1:0] e_page;
    logic                 e_use;
    logic                 e_empty;
    logic                 e_match;
    logic                 e_own;
    logic [ENT_W-1:0]     e_cleared;

    logic             scan_hit;
    logic             scan_last;
    logic             sweep_inst;
    logic             out_free;
    logic [IDX_W-1:0] dix_inc;
    logic             empty_inc;
    logic             empty_dec;
    logic [IDX_W+FRAME_W-1:0]   frame_ext;
    logic [CNT_W+REMOVED_W-1:0] removed_ext;

    cpr_frame_ram #(
        .DEPTH (NUM_FRAMES),
        .DW    (ENT_W),
        .AW    (IDX_W)
    ) u_frame_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

    assign e_owner   = rdata[ID_BITS-1:0];
    assign e_page    = rdata[ID_BITS +: PAGE_BITS];
    assign e_use     = rdata[ENT_W-1];
    assign e_empty   = (rdata == '0);
    assign e_own     = (e_owner == id_reg);
    assign e_match   = e_own && (e_page == page_reg);
    assign e_cleared = {1'b0, e_page, e_owner};
    assign dix_inc   = (dix_reg == LAST_IDX) ? '0 : dix_reg + 1'b1;

    assign scan_hit   = (state_reg == ST_SCAN) && dv_reg && (cmd_reg == CMD_ACCESS) && e_match;
    assign scan_last  = (state_reg == ST_SCAN) && dv_reg && (dix_reg == LAST_IDX);
    assign sweep_inst = (state_reg == ST_SWEEP) && !e_use;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign frame_ext   = {{FRAME_W{1'b0}}, frame_reg};
    assign removed_ext = {{REMOVED_W{1'b0}}, removed_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    state_next = ST_DONE;
                end else if (scan_last) begin
                    state_next = (cmd_reg == CMD_REMOVE) ? ST_DONE : ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sweep_inst) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        page_next     = page_reg;
        ptr_next      = ptr_reg;
        dv_next       = 1'b0;
        dix_next      = dix_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        hit_next      = hit_reg;
        frame_next    = frame_reg;
        removed_next  = removed_reg;
        hand_next     = hand_reg;
        fault_next    = fault_reg;
        cnt_en_next   = cnt_en_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        we            = 1'b0;
        waddr         = dix_reg;
        wdata         = rdata;
        raddr         = '0;
        empty_inc     = 1'b0;
        empty_dec     = 1'b0;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next      = cmd_t'(s_tuser);
                    id_next       = s_tdata[ID_BITS-1:0];
                    page_next     = s_tdata[ID_BITS +: PAGE_BITS];
                    raddr         = '0;
                    dv_next       = 1'b1;
                    dix_next      = '0;
                    ptr_next      = CNT_W'(1);
                    free_vld_next = 1'b0;
                    hit_next      = 1'b0;
                    frame_next    = '0;
                    removed_next  = '0;
                end
            end
            ST_SCAN: begin
                if (dv_reg) begin
                    if (cmd_reg == CMD_REMOVE) begin
                        if (e_own) begin
                            we           = 1'b1;
                            wdata        = '0;
                            removed_next = removed_reg + 1'b1;
                            empty_inc    = !e_empty;
                        end
                    end else if (e_match) begin
                        we         = 1'b1;
                        wdata      = {1'b1, e_page, e_owner};
                        empty_dec  = e_empty;
                        hit_next   = 1'b1;
                        frame_next = dix_reg;
                    end else if (!free_vld_reg && e_empty) begin
                        free_vld_next = 1'b1;
                        free_idx_next = dix_reg;
                    end
                end
                if (!scan_hit && (ptr_reg < FRAMES_CNT)) begin
                    raddr    = ptr_reg[IDX_W-1:0];
                    dv_next  = 1'b1;
                    dix_next = ptr_reg[IDX_W-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end else if (scan_last && !scan_hit && (cmd_reg == CMD_ACCESS)) begin
                    // miss: sweep starts at the first empty frame, else at the hand
                    if (free_vld_reg) begin
                        raddr = free_idx_reg;
                    end else if (e_empty) begin
                        raddr = dix_reg;
                    end else begin
                        raddr = hand_reg;
                    end
                    dv_next  = 1'b1;
                    dix_next = raddr;
                end
            end
            ST_SWEEP: begin
                we = 1'b1;
                if (e_use) begin
                    // second chance: clear the bit and move on, reading one frame ahead
                    wdata     = e_cleared;
                    empty_inc = (e_cleared == '0);
                    raddr     = dix_inc;
                    dv_next   = 1'b1;
                    dix_next  = dix_inc;
                end else begin
                    wdata      = {1'b1, page_reg, id_reg};
                    empty_dec  = e_empty;
                    frame_next = dix_reg;
                    hand_next  = dix_inc;
                    if (cnt_en_reg) begin
                        fault_next = fault_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if ((cmd_reg == CMD_ACCESS) && (empty_reg == '0)) begin
                        cnt_en_next = 1'b1;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, cnt_en_next, fault_reg,
                                     removed_ext[REMOVED_W-1:0], frame_ext[FRAME_W-1:0],
                                     hit_reg};
                end
            end
            default: begin
                dv_next = 1'b0;
            end
        endcase

        empty_next = empty_reg + CNT_W'(empty_inc) - CNT_W'(empty_dec);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dv_reg       <= 1'b0;
            hand_reg     <= '0;
            fault_reg    <= '0;
            cnt_en_reg   <= 1'b0;
            empty_reg    <= FRAMES_CNT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dv_reg       <= dv_next;
            hand_reg     <= hand_next;
            fault_reg    <= fault_next;
            cnt_en_reg   <= cnt_en_next;
            empty_reg    <= empty_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        page_reg     <= page_next;
        ptr_reg      <= ptr_next;
        dix_reg      <= dix_next;
        free_vld_reg <= free_vld_next;
        free_idx_reg <= free_idx_next;
        hit_reg      <= hit_next;
        frame_reg    <= frame_next;
        removed_reg  <= removed_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "clock_page_replacement_assert.svh"

    `CPR_ASSERT_NOW(a_empty_range, aclk, aresetn, 1'b1, empty_reg <= FRAMES_CNT, "empty frame count out of range")
    `CPR_ASSERT_NEXT(a_count_sticky, aclk, aresetn, cnt_en_reg, cnt_en_reg, "fault counting turned off")
    `CPR_ASSERT_NEXT(a_fault_gated, aclk, aresetn, !cnt_en_reg, $stable(fault_reg), "fault counted while counting off")

endmodule
